// ----- rtl/ufb_pkg.sv -----
// Package for the fractional-baud UART: action codes, register offsets,
// configuration indexes and the queue record between front and back end.
// No dependencies.
package ufb_pkg;

    localparam int ActionW  = 2;
    localparam int OffsetW  = 12;
    localparam int WdataW   = 11;
    localparam int RdataW   = 16;
    localparam int CfgAddrW = 5;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    localparam logic [OffsetW-1:0] OFF_DATA   = 12'h000;
    localparam logic [OffsetW-1:0] OFF_STATUS = 12'h004;
    localparam logic [OffsetW-1:0] OFF_FLAGS  = 12'h018;
    localparam logic [OffsetW-1:0] OFF_ICLEAR = 12'h044;

    localparam logic [2:0] CFG_BAUD_INT  = 3'd0;
    localparam logic [2:0] CFG_BAUD_FRAC = 3'd1;
    localparam logic [2:0] CFG_WORD_LEN  = 3'd2;
    localparam logic [2:0] CFG_PAR_EN    = 3'd3;
    localparam logic [2:0] CFG_PAR_EVEN  = 3'd4;
    localparam logic [2:0] CFG_TWO_STOP  = 3'd5;
    localparam logic [2:0] CFG_FIFO_EN   = 3'd6;
    localparam logic [2:0] CFG_ENABLES   = 3'd7;

    // Decoded operation handed from the front end to the back end
    typedef enum logic [2:0] {
        OP_NOP,
        OP_RD_DATA,
        OP_RD_STATUS,
        OP_RD_FLAGS,
        OP_WR_DATA,
        OP_WR_STATUS,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] wbyte;
        logic       line;
    } t_cmd;

    typedef struct packed {
        logic [15:0] baud_int;
        logic [5:0]  baud_frac;
        logic [1:0]  word_length;
        logic        parity_enable;
        logic        parity_even;
        logic        two_stop_bits;
        logic        fifo_enable;
        logic [2:0]  enable_bits;
    } t_cfg;

endpackage

// ----- rtl/ufb_in_if.sv -----
// Valid/ready channel interfaces for the UART items and results.
// No dependencies.
interface ufb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [11:0] reg_offset;
    logic [10:0] write_data;
    logic        rx_line;
    modport source (output valid, action, reg_offset, write_data, rx_line, input ready);
    modport sink   (input valid, action, reg_offset, write_data, rx_line, output ready);
endinterface

interface ufb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic        tx_line;
    logic        line_busy;
    modport source (output valid, read_data, tx_line, line_busy, input ready);
    modport sink   (input valid, read_data, tx_line, line_busy, output ready);
endinterface

// ----- rtl/ufb_front.sv -----
// Front end: accepts bus/tick items, decodes them and queues commands.
// Depends on ufb_pkg.
module ufb_front #(
    parameter int QDEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_action,
    input  logic [11:0]     i_reg_offset,
    input  logic [10:0]     i_write_data,
    input  logic            i_rx_line,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready,
    output ufb_pkg::t_cmd   o_cmd
);
    import ufb_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    t_cmd            r_q [QDEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    t_cmd            w_cmd;
    logic            w_push, w_pop;

    // Classify the item
    always_comb begin
        w_cmd.wbyte = i_write_data[7:0];
        w_cmd.line  = i_rx_line;
        w_cmd.op    = OP_NOP;
        unique case (t_action'(i_action))
            ACT_READ: begin
                if (i_reg_offset == OFF_DATA)        w_cmd.op = OP_RD_DATA;
                else if (i_reg_offset == OFF_STATUS) w_cmd.op = OP_RD_STATUS;
                else if (i_reg_offset == OFF_FLAGS)  w_cmd.op = OP_RD_FLAGS;
            end
            ACT_WRITE: begin
                if (i_reg_offset == OFF_DATA)        w_cmd.op = OP_WR_DATA;
                else if (i_reg_offset == OFF_STATUS) w_cmd.op = OP_WR_STATUS;
            end
            ACT_TICK: w_cmd.op = OP_TICK;
            default:  w_cmd.op = OP_NOP;
        endcase
    end

    assign o_ready     = (r_cnt != QDEPTH[PW:0]);
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == PW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            if (w_pop)  r_rp <= (r_rp == PW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
    end

    ap_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QDEPTH) else $error("queue count overflow");
    ap_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count missed push");
    ap_empty_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> r_wp == r_rp) else $error("empty queue pointers differ");
endmodule

// ----- rtl/ufb_back.sv -----
// Back end: FIFOs, fractional baud divider, transmitter, receiver and
// the result register. Depends on ufb_pkg.
module ufb_back #(
    parameter int FIFO_DEPTH = 16,
    parameter int OVERSAMPLE = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    output logic            o_cmd_ready,
    input  ufb_pkg::t_cmd   i_cmd,
    input  ufb_pkg::t_cfg   i_cfg,
    input  logic            i_accum_clr,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [15:0]     o_read_data,
    output logic            o_tx_line,
    output logic            o_line_busy
);
    import ufb_pkg::*;

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int LW = $clog2(FIFO_DEPTH + 1);
    localparam int SW = $clog2(OVERSAMPLE + 1);

    // Fold a pointer sum below twice the depth back into the FIFO range
    function automatic logic [AW-1:0] wrap_idx(input logic [LW:0] s);
        logic [LW:0] t;
        t = (s >= (LW+1)'(FIFO_DEPTH)) ? s - (LW+1)'(FIFO_DEPTH) : s;
        return t[AW-1:0];
    endfunction

    logic [7:0]    r_tx_mem [FIFO_DEPTH];
    logic [11:0]   r_rx_mem [FIFO_DEPTH];
    logic [LW-1:0] r_tx_level, r_rx_level;
    logic [AW-1:0] r_tx_head, r_rx_head;
    logic [22:0]   r_accum;
    logic [11:0]   r_tx_frame, r_rx_frame;
    logic [3:0]    r_tx_left, r_rx_left;
    logic [SW-1:0] r_tx_sub, r_rx_sub;
    logic          r_rx_active;
    logic [3:0]    r_err;
    logic          r_out_valid;
    logic [15:0]   r_rdata;

    logic [LW-1:0] w_cap;
    logic          w_go;
    logic [22:0]   w_div, w_acc_add, w_acc_sub;
    logic          w_en;

    assign w_go        = i_cmd_valid && (!r_out_valid || i_ready);
    assign o_cmd_ready = !r_out_valid || i_ready;
    assign o_valid     = r_out_valid;
    assign o_read_data = r_rdata;
    assign o_tx_line   = r_tx_frame[0];
    assign o_line_busy = (r_tx_level != '0) || (r_tx_left != '0);
    assign w_cap = i_cfg.fifo_enable ? LW'(FIFO_DEPTH) : LW'(1);

    // Fractional divider: one 16x enable when the accumulator passes the divisor
    always_comb begin
        w_div = {1'b0, i_cfg.baud_int, i_cfg.baud_frac};
        if (w_div < 23'd64) w_div = 23'd64;
        w_acc_add = r_accum + 23'd64;
        w_acc_sub = w_acc_add - w_div;
        w_en = (i_cmd.op == OP_TICK) && i_cfg.enable_bits[0] && (w_acc_add >= w_div);
    end

    function automatic logic par_of(input logic [7:0] d, input logic even);
        return even ? ^d : ~^d;
    endfunction

    // Transmitter next state
    logic [11:0]   n_tx_frame;
    logic [3:0]    n_tx_left;
    logic [SW-1:0] n_tx_sub;
    logic          w_tx_pop;
    logic [7:0]    w_td;
    logic [7:0]    w_mask;
    logic [3:0]    w_pos;
    logic [11:0]   w_f;
    always_comb begin
        n_tx_frame = r_tx_frame;
        n_tx_left  = r_tx_left;
        n_tx_sub   = r_tx_sub;
        w_tx_pop   = 1'b0;
        w_mask     = 8'hFF >> (2'd3 - i_cfg.word_length);
        w_td       = r_tx_mem[r_tx_head] & w_mask;
        w_pos      = 4'd6 + 4'(i_cfg.word_length);
        w_f        = {3'b0, w_td, 1'b0};
        if (r_tx_left != '0) begin
            n_tx_sub = r_tx_sub + 1'b1;
            if (n_tx_sub >= SW'(OVERSAMPLE)) begin
                n_tx_sub   = '0;
                n_tx_frame = {1'b1, r_tx_frame[11:1]};
                n_tx_left  = r_tx_left - 1'b1;
            end
        end
        if (n_tx_left == '0 && i_cfg.enable_bits[1] && r_tx_level != '0) begin
            w_tx_pop = 1'b1;
            if (i_cfg.parity_enable) begin
                w_f[w_pos] = par_of(w_td, i_cfg.parity_even);
                w_pos      = w_pos + 1'b1;
            end
            w_f        = w_f | (12'hFFF << w_pos);
            n_tx_frame = w_f;
            n_tx_left  = w_pos + 4'd1 + 4'(i_cfg.two_stop_bits);
            n_tx_sub   = '0;
        end
    end

    // Receiver next state
    logic [11:0]   n_rx_frame;
    logic [3:0]    n_rx_left;
    logic [SW-1:0] n_rx_sub;
    logic          n_rx_active;
    logic          w_rx_done;
    logic [11:0]   w_rx_entry;
    logic [3:0]    w_total;
    logic [7:0]    w_rd;
    logic          w_stop, w_pbit, w_be;
    always_comb begin
        n_rx_frame  = r_rx_frame;
        n_rx_left   = r_rx_left;
        n_rx_sub    = r_rx_sub;
        n_rx_active = r_rx_active;
        w_rx_done   = 1'b0;
        w_total     = 4'd7 + 4'(i_cfg.word_length) + 4'(i_cfg.parity_enable);
        w_rd        = '0;
        w_stop      = 1'b0;
        w_pbit      = 1'b0;
        w_be        = 1'b0;
        w_rx_entry  = '0;
        if (!r_rx_active) begin
            if (!i_cmd.line) begin
                n_rx_active = 1'b1;
                n_rx_sub    = SW'(OVERSAMPLE / 2);
                n_rx_left   = w_total;
                n_rx_frame  = '0;
            end
        end else if (r_rx_left == '0) begin
            if (i_cmd.line) n_rx_active = 1'b0;
        end else begin
            n_rx_sub = r_rx_sub + 1'b1;
            if (n_rx_sub >= SW'(OVERSAMPLE)) begin
                n_rx_sub = '0;
                if (r_rx_left == w_total && i_cmd.line) begin
                    n_rx_active = 1'b0;
                end else begin
                    n_rx_frame = {i_cmd.line, r_rx_frame[11:1]};
                    n_rx_left  = r_rx_left - 1'b1;
                    if (n_rx_left == '0) begin
                        w_rx_done = 1'b1;
                        w_rd = 8'(n_rx_frame >> (4'(i_cfg.parity_enable ? 10 : 11)
                               - (4'd5 + 4'(i_cfg.word_length))))
                               & (8'hFF >> (2'd3 - i_cfg.word_length));
                        w_stop = n_rx_frame[11];
                        w_pbit = n_rx_frame[10];
                        w_be   = (w_rd == '0) && !w_stop
                                 && (!i_cfg.parity_enable || !w_pbit);
                        w_rx_entry = {1'b0, w_be,
                            i_cfg.parity_enable && (w_pbit != par_of(w_rd, i_cfg.parity_even)),
                            !w_stop, w_rd};
                        n_rx_active = w_be;
                    end
                end
            end
        end
    end

    logic          w_tx_push, w_rx_pop, w_rx_push, w_rx_ovr;
    logic [AW-1:0] w_tx_waddr, w_rx_waddr, w_rx_last;
    logic [15:0]   n_rdata;
    logic          w_rx_en;
    assign w_rx_en    = w_en && i_cfg.enable_bits[2];
    assign w_tx_push  = w_go && i_cmd.op == OP_WR_DATA && r_tx_level < w_cap;
    assign w_rx_pop   = w_go && i_cmd.op == OP_RD_DATA && r_rx_level != '0;
    assign w_rx_push  = w_go && w_rx_en && w_rx_done && r_rx_level < w_cap;
    assign w_rx_ovr   = w_go && w_rx_en && w_rx_done && !(r_rx_level < w_cap);
    assign w_tx_waddr = wrap_idx((LW+1)'(r_tx_head) + (LW+1)'(r_tx_level));
    assign w_rx_waddr = wrap_idx((LW+1)'(r_rx_head) + (LW+1)'(r_rx_level));
    assign w_rx_last  = wrap_idx((LW+1)'(r_rx_head) + (LW+1)'(r_rx_level)
                                 - (LW+1)'(1));

    // Read data for the current command
    always_comb begin
        n_rdata = '0;
        case (i_cmd.op)
            OP_RD_DATA:   if (r_rx_level != '0) n_rdata = {4'b0, r_rx_mem[r_rx_head]};
            OP_RD_STATUS: n_rdata = {12'b0, r_err};
            OP_RD_FLAGS:  n_rdata = {8'b0, r_tx_level == '0, r_rx_level >= w_cap,
                                     r_tx_level >= w_cap, r_rx_level == '0,
                                     o_line_busy, 3'b0};
            default:      n_rdata = '0;
        endcase
    end

    // FIFO storage
    always_ff @(posedge i_clk) begin
        if (w_tx_push) r_tx_mem[w_tx_waddr] <= i_cmd.wbyte;
        if (w_rx_push) r_rx_mem[w_rx_waddr] <= w_rx_entry;
        if (w_rx_ovr && r_rx_level != '0) r_rx_mem[w_rx_last][11] <= 1'b1;
        if (w_go) r_rdata <= n_rdata;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_level  <= '0;
            r_tx_head   <= '0;
            r_rx_level  <= '0;
            r_rx_head   <= '0;
            r_accum     <= '0;
            r_tx_frame  <= 12'hFFF;
            r_tx_left   <= '0;
            r_tx_sub    <= '0;
            r_rx_frame  <= '0;
            r_rx_left   <= '0;
            r_rx_sub    <= '0;
            r_rx_active <= 1'b0;
            r_err       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_go) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
            if (i_accum_clr) begin
                r_accum <= '0;
            end else if (w_go && i_cmd.op == OP_TICK && i_cfg.enable_bits[0]) begin
                if (w_acc_add < w_div) r_accum <= w_acc_add;
                else if (w_acc_sub >= w_div) r_accum <= '0;
                else r_accum <= w_acc_sub;
            end
            if (w_go && w_en) begin
                r_tx_frame <= n_tx_frame;
                r_tx_left  <= n_tx_left;
                r_tx_sub   <= n_tx_sub;
                if (w_tx_pop) r_tx_head <= wrap_idx((LW+1)'(r_tx_head) + (LW+1)'(1));
            end
            if (w_rx_en && w_go) begin
                r_rx_frame  <= n_rx_frame;
                r_rx_left   <= n_rx_left;
                r_rx_sub    <= n_rx_sub;
                r_rx_active <= n_rx_active;
            end
            r_tx_level <= r_tx_level + LW'(w_tx_push)
                          - LW'(w_go && w_en && w_tx_pop);
            r_rx_level <= r_rx_level + LW'(w_rx_push) - LW'(w_rx_pop);
            if (w_rx_pop) r_rx_head <= wrap_idx((LW+1)'(r_rx_head) + (LW+1)'(1));
            if (w_go && i_cmd.op == OP_WR_STATUS) r_err <= '0;
            else if (w_rx_ovr) r_err <= r_err | 4'b1000;
            else if (w_rx_pop) r_err <= r_err | {1'b0, r_rx_mem[r_rx_head][10:8]};
        end
    end

    ap_tx_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_level <= LW'(FIFO_DEPTH)) else $error("tx level overflow");
    ap_rx_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_level <= LW'(FIFO_DEPTH)) else $error("rx level overflow");
    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> $stable(r_rdata)) else $error("result changed");
    ap_idle_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tx_left == '0) |-> r_tx_frame[0]) else $error("tx line low when idle");
endmodule

// ----- rtl/uart_fifo_fractional_baud.sv -----
// Top level of the UART with FIFOs and fractional baud divider.
// Depends on ufb_pkg, ufb_in_if/ufb_out_if, ufb_front and ufb_back.
//
//  Channel  Dir  Handshake        Payload
//  in       in   valid/ready      action, reg_offset, write_data, rx_line
//  out      out  valid/ready      read_data, tx_line, line_busy
//  cfg      in   APB write/read   eight registers at 4*index
//
// One item per cycle while the output is not stalled; a result passes through the decode
// queue entry, then the back-end result register.
// Synchronous active-low reset clears all control state; FIFO storage is not cleared.
// A stalled output holds the back end; the two-entry queue then fills and
// drops in_ready.
module uart_fifo_fractional_baud #(
    parameter int FIFO_DEPTH = 16,
    parameter int OVERSAMPLE = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ufb_in_if.sink                     in_ch,
    ufb_out_if.source                  out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ufb_pkg::CfgAddrW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import ufb_pkg::*;

    t_cfg  r_cfg;
    logic  w_wr, w_cmd_valid, w_cmd_ready, w_clr;
    t_cmd  w_cmd;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_clr  = w_wr && (paddr[4:2] == CFG_BAUD_INT || paddr[4:2] == CFG_BAUD_FRAC)
                    && paddr[1:0] == 2'b00;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{baud_int: 16'd1, baud_frac: '0, word_length: '0,
                       parity_enable: 1'b0, parity_even: 1'b0, two_stop_bits: 1'b0,
                       fifo_enable: 1'b0, enable_bits: 3'd6};
        end else if (w_wr && paddr[1:0] == 2'b00) begin
            unique case (paddr[4:2])
                CFG_BAUD_INT:  r_cfg.baud_int      <= pwdata[15:0];
                CFG_BAUD_FRAC: r_cfg.baud_frac     <= pwdata[5:0];
                CFG_WORD_LEN:  r_cfg.word_length   <= pwdata[1:0];
                CFG_PAR_EN:    r_cfg.parity_enable <= pwdata[0];
                CFG_PAR_EVEN:  r_cfg.parity_even   <= pwdata[0];
                CFG_TWO_STOP:  r_cfg.two_stop_bits <= pwdata[0];
                CFG_FIFO_EN:   r_cfg.fifo_enable   <= pwdata[0];
                CFG_ENABLES:   r_cfg.enable_bits   <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        prdata = '0;
        unique case (paddr[4:2])
            CFG_BAUD_INT:  prdata = {16'b0, r_cfg.baud_int};
            CFG_BAUD_FRAC: prdata = {26'b0, r_cfg.baud_frac};
            CFG_WORD_LEN:  prdata = {30'b0, r_cfg.word_length};
            CFG_PAR_EN:    prdata = {31'b0, r_cfg.parity_enable};
            CFG_PAR_EVEN:  prdata = {31'b0, r_cfg.parity_even};
            CFG_TWO_STOP:  prdata = {31'b0, r_cfg.two_stop_bits};
            CFG_FIFO_EN:   prdata = {31'b0, r_cfg.fifo_enable};
            CFG_ENABLES:   prdata = {29'b0, r_cfg.enable_bits};
            default:       prdata = '0;
        endcase
    end

    ufb_front #(.QDEPTH(2)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_ch.valid),
        .o_ready      (in_ch.ready),
        .i_action     (in_ch.action),
        .i_reg_offset (in_ch.reg_offset),
        .i_write_data (in_ch.write_data),
        .i_rx_line    (in_ch.rx_line),
        .o_cmd_valid  (w_cmd_valid),
        .i_cmd_ready  (w_cmd_ready),
        .o_cmd        (w_cmd)
    );

    ufb_back #(.FIFO_DEPTH(FIFO_DEPTH), .OVERSAMPLE(OVERSAMPLE)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .i_cfg       (r_cfg),
        .i_accum_clr (w_clr),
        .o_valid     (out_ch.valid),
        .i_ready     (out_ch.ready),
        .o_read_data (out_ch.read_data),
        .o_tx_line   (out_ch.tx_line),
        .o_line_busy (out_ch.line_busy)
    );
endmodule
